>>> rtl/vtac_pkg.sv
// ----------------------------------------------------------------------------
// vtac_pkg
// Shared constants and types for the turret aim controller.
// ----------------------------------------------------------------------------
package vtac_pkg;

  localparam int unsigned LimitWidth  = 23;
  localparam int unsigned EncWidth    = 24;
  localparam int unsigned XWidth      = 9;
  localparam int unsigned YWidth      = 8;
  localparam int unsigned WWidth      = 9;
  localparam int unsigned HWidth      = 8;
  localparam int unsigned AreaWidth   = WWidth + HWidth;
  localparam int unsigned TenthsWidth = 4;
  localparam int unsigned InDataWidth = 64;
  localparam int unsigned OutDataWidth = 8;
  localparam int unsigned CfgIdxWidth = 1;

  localparam logic [YWidth-1:0]    YLimit    = 8'd90;
  localparam logic [AreaWidth-1:0] AreaLimit = 17'd3935;
  localparam logic [XWidth-1:0]    CentreLo  = 9'd150;
  localparam logic [XWidth-1:0]    CentreHi  = 9'd170;
  localparam logic [XWidth-1:0]    SlowLo    = 9'd85;
  localparam logic [XWidth-1:0]    SlowHi    = 9'd235;
  localparam logic [XWidth-1:0]    Middle    = 9'd160;

  localparam logic signed [TenthsWidth-1:0] TenthsFast = 4'sd4;
  localparam logic signed [TenthsWidth-1:0] TenthsSlow = 4'sd2;
  localparam logic signed [TenthsWidth-1:0] TenthsStop = 4'sd0;

  // register indexes on the configuration port
  localparam logic [CfgIdxWidth-1:0] RegEncoderLimit  = 1'b0;
  localparam logic [CfgIdxWidth-1:0] RegAutonomousMode = 1'b1;

  // input kinds carried on tuser
  localparam logic CmdBlob = 1'b0;
  localparam logic CmdTick = 1'b1;

  typedef struct packed {
    logic                          centred;
    logic signed [TenthsWidth-1:0] tenths;
  } drive_t;

endpackage

>>> rtl/vtac_drive.sv
// ----------------------------------------------------------------------------
// vtac_drive
// Maps the chosen blob column to a swivel speed and a centred flag.
// ----------------------------------------------------------------------------
module vtac_drive
  import vtac_pkg::*;
(
  input  logic [XWidth-1:0] bx,
  output drive_t            drive
);

  logic slow;
  logic signed [TenthsWidth-1:0] mag;

  always_comb begin
    slow          = (bx >= SlowLo) && (bx <= SlowHi);
    mag           = slow ? TenthsSlow : TenthsFast;
    drive.centred = (bx >= CentreLo) && (bx <= CentreHi);
    if (drive.centred) begin
      drive.tenths = TenthsStop;
    end else if (bx < Middle) begin
      drive.tenths = -mag;
    end else begin
      drive.tenths = mag;
    end
  end

endmodule

>>> rtl/vision_turret_aim_controller_core.sv
// ----------------------------------------------------------------------------
// vision_turret_aim_controller_core
// Keeps the best blob of a frame and issues a swivel command at frame end;
// empty-frame ticks run the search sweep with edge-triggered reversal.
// ----------------------------------------------------------------------------
// Each accepted item's result is loaded into the output register on its transfer.
// Throughput: one item per cycle; the frame state is updated on each transfer and
// the result register on each transfer that yields a result, and the input is held
// off only while a result waits and the output side stalls.
// Reset (rst, synchronous): sweep positive, frame state and flags cleared,
// both configuration registers zero, output register empty.
module vision_turret_aim_controller_core
  import vtac_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // configuration write port
  input  logic                    wr_en,
  input  logic [CfgIdxWidth-1:0]  wr_index,
  input  logic [LimitWidth-1:0]   wr_data,
  // input stream
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // [8:0] blob_x, [16:9] blob_y, [25:17] blob_width, [33:26] blob_height,
  // [57:34] encoder_pos, [63:58] zero
  input  logic [InDataWidth-1:0]  s_tdata,
  input  logic                    s_tlast,  // last_blob
  input  logic                    s_tuser,  // cmd
  // result stream
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // [0] drive_set, [4:1] drive_tenths, [5] target_acquired, [6] finished,
  // [7] zero
  output logic [OutDataWidth-1:0] m_tdata
);

  logic [LimitWidth-1:0] encoder_limit;
  logic                  autonomous_mode;

  logic              sweep_positive, sweep_positive_next;
  logic              fwd_beyond, fwd_beyond_next;
  logic              rev_beyond, rev_beyond_next;
  logic              acquired_flag, acquired_flag_next;
  logic [1:0]        blob_count, blob_count_next;
  logic              best_found, best_found_next;
  logic [XWidth-1:0] best_x, best_x_next;
  logic [YWidth-1:0] best_y, best_y_next;

  logic                          out_valid_next;
  logic                          drive_set_next;
  logic signed [TenthsWidth-1:0] tenths_next;

  logic              accept;
  logic [XWidth-1:0] in_x;
  logic [YWidth-1:0] in_y;
  logic [WWidth-1:0] in_w;
  logic [HWidth-1:0] in_h;
  logic signed [EncWidth-1:0] in_pos;
  logic signed [EncWidth:0]   pos_ext, lim_ext;
  logic [AreaWidth-1:0] area;
  logic qualifies, take;
  logic [XWidth-1:0] cand_x;
  logic fwd, rev, fwd_edge, rev_edge;
  drive_t drive;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign in_x   = s_tdata[8:0];
  assign in_y   = s_tdata[16:9];
  assign in_w   = s_tdata[25:17];
  assign in_h   = s_tdata[33:26];
  assign in_pos = s_tdata[57:34];

  assign pos_ext = {in_pos[EncWidth-1], in_pos};
  assign lim_ext = {2'b00, encoder_limit};
  assign area    = AreaWidth'(in_w) * AreaWidth'(in_h);

  assign qualifies = (in_y <= YLimit) && (area < AreaLimit);
  assign take      = qualifies && (!best_found || (best_y < in_y));
  // column of the frame's best blob including the current one
  assign cand_x    = take ? in_x : best_x;

  vtac_drive u_drive (
    .bx    (cand_x),
    .drive (drive)
  );

  always_comb begin
    sweep_positive_next = sweep_positive;
    fwd_beyond_next     = fwd_beyond;
    rev_beyond_next     = rev_beyond;
    acquired_flag_next  = acquired_flag;
    blob_count_next     = blob_count;
    best_found_next     = best_found;
    best_x_next         = best_x;
    best_y_next         = best_y;
    out_valid_next      = 1'b0;
    drive_set_next      = 1'b0;
    tenths_next         = TenthsStop;

    fwd       = pos_ext > lim_ext;
    rev       = pos_ext < -lim_ext;
    fwd_edge  = fwd && !fwd_beyond;
    rev_edge  = rev && !rev_beyond;

    if (s_tuser == CmdTick) begin
      // drop any partial frame and run the sweep
      fwd_beyond_next = fwd;
      rev_beyond_next = rev;
      if (rev_edge) begin
        sweep_positive_next = 1'b1;
      end else if (fwd_edge) begin
        sweep_positive_next = 1'b0;
      end
      acquired_flag_next = 1'b0;
      blob_count_next    = 2'd0;
      best_found_next    = 1'b0;
      best_x_next        = '0;
      best_y_next        = '0;
      out_valid_next     = 1'b1;
      drive_set_next     = 1'b1;
      tenths_next        = sweep_positive_next ? TenthsFast : -TenthsFast;
    end else begin
      if (take) begin
        best_found_next = 1'b1;
        best_x_next     = in_x;
        best_y_next     = in_y;
      end
      if (blob_count != 2'd2) begin
        blob_count_next = blob_count + 2'd1;
      end
      if (s_tlast) begin
        out_valid_next = 1'b1;
        if (!best_found_next) begin
          if (blob_count_next == 2'd2) begin
            acquired_flag_next = 1'b0;
          end
        end else begin
          drive_set_next     = 1'b1;
          tenths_next        = drive.tenths;
          acquired_flag_next = drive.centred;
        end
        blob_count_next = 2'd0;
        best_found_next = 1'b0;
        best_x_next     = '0;
        best_y_next     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      encoder_limit   <= '0;
      autonomous_mode <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        RegEncoderLimit:   encoder_limit   <= wr_data;
        RegAutonomousMode: autonomous_mode <= wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_positive <= 1'b1;
      fwd_beyond     <= 1'b0;
      rev_beyond     <= 1'b0;
      acquired_flag  <= 1'b0;
      blob_count     <= 2'd0;
      best_found     <= 1'b0;
      best_x         <= '0;
      best_y         <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (accept) begin
        sweep_positive <= sweep_positive_next;
        fwd_beyond     <= fwd_beyond_next;
        rev_beyond     <= rev_beyond_next;
        acquired_flag  <= acquired_flag_next;
        blob_count     <= blob_count_next;
        best_found     <= best_found_next;
        best_x         <= best_x_next;
        best_y         <= best_y_next;
        m_tvalid       <= out_valid_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result payload: load only on a transfer that yields a result
  always_ff @(posedge clk) begin
    if (accept && out_valid_next) begin
      m_tdata <= {1'b0, autonomous_mode && acquired_flag_next, acquired_flag_next,
                  tenths_next, drive_set_next};
    end
  end

endmodule
